/* rtl/psplim_pkg.sv */
package psplim_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 8;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(3);
    localparam logic [CNT_W-1:0] FIRST_COUNT = CNT_W'(1);

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_COUNTED = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

endpackage

/* rtl/per_source_packet_limiter.sv */
// Per-source packet limiter.
// Input channel: i_in_valid / o_in_stall carries one word, the packet's
// source address. Output channel: o_out_valid / i_out_stall carries one
// word per input word: o_forward and o_status (added, counted, blocked,
// table full). A word moves at a rising edge with valid high, stall low.
// i_cfg_we writes i_cfg_data into the packet limit; write only when idle.
// One item at a time: after acceptance the table is read one entry per
// cycle through its single read port, compared, then updated. The scan
// stops at the matching entry; a miss reads every occupied entry.
// The result lands in an output register, so the next word may be taken
// while it waits; if the receiver still stalls when the next result is
// ready, the block holds in its decide step and the table is untouched.
// Reset (synchronous, active low) empties the table, sets the limit to 3
// and drops the output valid; table contents are not cleared, only
// occupied entries are ever compared.
module per_source_packet_limiter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  psplim_pkg::t_addr         i_source_address,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_forward,
    output logic [1:0]                o_status,
    input  logic                      i_cfg_we,
    input  psplim_pkg::t_cnt          i_cfg_data
);
    import psplim_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    t_addr r_addr_mem [TABLE_ENTRIES];
    t_cnt  r_cnt_mem  [TABLE_ENTRIES];

    logic [1:0]        r_state;
    logic [USED_W-1:0] r_used;
    t_cnt              r_limit;
    t_addr             r_addr;
    logic [USED_W-1:0] r_idx;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pend_idx;
    t_addr             r_rd_addr;
    t_cnt              r_rd_cnt;
    logic              r_hit;
    logic [IDX_W-1:0]  r_slot;
    t_cnt              r_cnt;
    logic              r_out_valid;
    logic              r_forward;
    logic [1:0]        r_status;

    logic              issue;
    logic              match;
    logic              out_free;
    logic              leave;
    logic              full;
    logic              blocked;
    logic              wr_addr_en;
    logic              wr_cnt_en;
    logic [IDX_W-1:0]  wr_idx;
    t_cnt              wr_cnt;
    logic              n_forward;
    logic [1:0]        n_status;

    assign issue    = (r_state == S_SCAN) && (r_idx != r_used);
    assign match    = r_pend && (r_rd_addr == r_addr);
    assign out_free = !r_out_valid || !i_out_stall;
    assign leave    = (r_state == S_DECIDE) && out_free;
    assign full     = (r_used == USED_W'(TABLE_ENTRIES));
    assign blocked  = r_hit && (r_cnt >= r_limit);
    assign wr_idx   = r_hit ? r_slot : r_used[IDX_W-1:0];

    always_comb begin
        wr_addr_en = 1'b0;
        wr_cnt_en  = 1'b0;
        wr_cnt     = FIRST_COUNT;
        n_forward  = 1'b1;
        n_status   = ST_FULL;
        if (!r_hit) begin
            if (!full) begin
                wr_addr_en = leave;
                wr_cnt_en  = leave;
                n_status   = ST_ADDED;
            end
        end else if (blocked) begin
            n_forward = 1'b0;
            n_status  = ST_BLOCKED;
        end else begin
            wr_cnt_en = leave;
            wr_cnt    = r_cnt + FIRST_COUNT;
            n_status  = ST_COUNTED;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_addr_en) begin
            r_addr_mem[wr_idx] <= r_addr;
        end
        if (wr_cnt_en) begin
            r_cnt_mem[wr_idx] <= wr_cnt;
        end
        r_rd_addr <= r_addr_mem[r_idx[IDX_W-1:0]];
        r_rd_cnt  <= r_cnt_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_limit     <= LIMIT_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (leave) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (i_in_valid) begin
                        r_addr  <= i_source_address;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend     <= issue && !match;
                    r_pend_idx <= r_idx[IDX_W-1:0];
                    if (issue) begin
                        r_idx <= r_idx + USED_W'(1);
                    end
                    if (match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_pend_idx;
                        r_cnt   <= r_rd_cnt;
                        r_state <= S_DECIDE;
                    end else if (!issue) begin
                        r_hit   <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        r_forward   <= n_forward;
                        r_status    <= n_status;
                        if (!r_hit && !full) begin
                            r_used <= r_used + USED_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_forward   = r_forward;
    assign o_status    = r_status;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_ENTRIES))
        else $error("occupancy beyond table size");

    a_fwd_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forward == (o_status != ST_BLOCKED)))
        else $error("forward disagrees with status");

    a_used_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |->
            (o_out_valid && o_status == ST_ADDED && r_used == $past(r_used) + USED_W'(1)))
        else $error("occupancy changed without an added entry");

endmodule

/* bench/tb.sv */
module tb;
    import psplim_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 25;
    localparam int N_DIRECTED  = 24;
    localparam int N_PHASES    = 7;

    typedef struct packed {
        logic       fwd;
        logic [1:0] st;
    } t_verdict;

    typedef struct {
        t_addr    addr;
        bit       typed;
        t_verdict v;
    } t_drow;

    localparam t_verdict V_ADDED   = '{1'b1, ST_ADDED};
    localparam t_verdict V_COUNTED = '{1'b1, ST_COUNTED};
    localparam t_verdict V_BLOCKED = '{1'b0, ST_BLOCKED};
    localparam t_verdict V_FULL    = '{1'b1, ST_FULL};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_addr      src_addr  = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       fwd;
    logic [1:0] status;
    logic       cfg_we    = 1'b0;
    t_cnt       cfg_data  = '0;

    t_addr    seen_addr [TABLE_ENTRIES];
    t_cnt     seen_cnt  [TABLE_ENTRIES];
    int       seen_used = 0;
    t_cnt     limit_now = LIMIT_RESET;
    t_verdict verdict_q [$];
    int       errors      = 0;
    int       words_out   = 0;
    int       idle_cycles = 0;
    bit       quiet_in    = 1'b0;
    bit       quiet_out   = 1'b0;

    per_source_packet_limiter dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_source_address (src_addr),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_forward        (fwd),
        .o_status         (status),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_verdict judge_packet(input t_addr a);
        t_verdict v;
        int       hit;
        int       k;
        hit = -1;
        for (k = 0; k < seen_used; k++) begin
            if (hit < 0 && seen_addr[k] == a) hit = k;
        end
        if (hit < 0) begin
            if (seen_used < TABLE_ENTRIES) begin
                seen_addr[seen_used] = a;
                seen_cnt[seen_used]  = FIRST_COUNT;
                seen_used++;
                v = V_ADDED;
            end else begin
                v = V_FULL;
            end
        end else if (seen_cnt[hit] >= limit_now) begin
            v = V_BLOCKED;
        end else begin
            seen_cnt[hit] = seen_cnt[hit] + 1'b1;
            v = V_COUNTED;
        end
        return v;
    endfunction

    // mostly known sources, entry 0 favoured so its count climbs to the top limit
    function automatic t_addr pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return seen_addr[0];
        if (r < 70) return seen_addr[$urandom_range(0, seen_used - 1)];
        if (r < 90) return t_addr'($urandom);
        return seen_addr[$urandom_range(0, seen_used - 1)] ^ (t_addr'(1) << $urandom_range(0, 31));
    endfunction

    task automatic offer_address(input t_addr a, input bit typed, input t_verdict typed_v);
        int       gap;
        t_verdict v;
        if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        src_addr <= a;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        v = judge_packet(a);
        verdict_q.push_back(typed ? typed_v : v);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input t_cnt v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_now = v;
    endtask

    initial begin : run_stimulus
        t_drow rows        [N_DIRECTED];
        t_cnt  phase_limit [N_PHASES];
        int    phase_items [N_PHASES];

        rows = '{
            '{32'h0000_0000, 1'b1, V_ADDED},
            '{32'h0000_0000, 1'b1, V_COUNTED},
            '{32'h0000_0000, 1'b1, V_COUNTED},
            '{32'h0000_0000, 1'b1, V_BLOCKED},
            '{32'hFFFF_FFFF, 1'b1, V_ADDED},
            '{32'hFFFF_FFFF, 1'b1, V_COUNTED},
            '{32'h8000_0000, 1'b0, V_ADDED},
            '{32'h0000_0001, 1'b0, V_ADDED},
            '{32'h7FFF_FFFF, 1'b0, V_ADDED},
            '{32'hFFFF_FFFE, 1'b0, V_ADDED},
            '{32'hC0A8_0001, 1'b0, V_ADDED},
            '{32'h0A00_0001, 1'b0, V_ADDED},
            '{32'hAAAA_AAAA, 1'b0, V_ADDED},
            '{32'h5555_5555, 1'b0, V_ADDED},
            '{32'h7F00_0001, 1'b0, V_ADDED},
            '{32'hDEAD_BEEF, 1'b0, V_ADDED},
            '{32'h0102_0304, 1'b0, V_ADDED},
            '{32'hFEDC_BA98, 1'b0, V_ADDED},
            '{32'h00FF_00FF, 1'b0, V_ADDED},
            '{32'hFF00_FF00, 1'b0, V_ADDED},
            '{32'h1234_5678, 1'b1, V_FULL},
            '{32'hFFFF_FFFF, 1'b0, V_ADDED},
            '{32'hFFFF_FFFF, 1'b1, V_BLOCKED},
            '{32'h0000_0000, 1'b1, V_BLOCKED}
        };
        // lowering to 1 and 0 leaves stored counts above the limit
        phase_limit = '{8'd255, 8'd1, 8'd0, 8'd7, 8'd128, 8'd255, 8'd2};
        phase_items = '{500, 200, 150, 250, 300, 400, 150};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i]) offer_address(rows[i].addr, rows[i].typed, rows[i].v);
        for (int p = 0; p < N_PHASES; p++) begin
            settle_block();
            write_limit(phase_limit[p]);
            repeat (phase_items[p]) offer_address(pick_address(), 1'b0, V_ADDED);
        end
        settle_block();
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin : take_results
        int       w;
        t_verdict want;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
            if (words_out == HOLD_AT) w = HOLD_CYCLES;
            else w = quiet_out ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            words_out++;
            if (verdict_q.size() == 0) begin
                $error("unexpected word: forward %0b status %0d", fwd, status);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (fwd !== want.fwd) begin
                    $error("forward: expected %0b, got %0b", want.fwd, fwd);
                    errors++;
                end
                if (status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
rtl/psplim_pkg.sv
rtl/per_source_packet_limiter.sv
bench/tb.sv
